// File: hw/rtl/ftt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftt_pkg: shared types and constants for the failover target table
// Codes, status values and sequencer states used by the table modules.
// ----------------------------------------------------------------------------
package ftt_pkg;

  localparam int unsigned ENTRIES_DEF = 32;

  localparam int unsigned NODE_W = 32;
  localparam int unsigned DEST_W = 8;

  // item kind carried on tuser
  localparam logic MODE_SET = 1'b0;
  localparam logic MODE_GET = 1'b1;

  // failover target codes (renumbered)
  localparam logic [DEST_W-1:0] FO_ACTIVE_ONLY    = 8'd0;
  localparam logic [DEST_W-1:0] FO_ALTERNATE_ONLY = 8'd1;
  localparam logic              FO_TGT_DEFAULT    = 1'b0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CODE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/ftt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftt_mem: entry storage
// One write port and one registered read port holding node and target.
// ----------------------------------------------------------------------------
module ftt_mem #(
  parameter int unsigned ENTRIES = ftt_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [ftt_pkg::NODE_W-1:0] wr_node,
  input  logic                      wr_target,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [ftt_pkg::NODE_W-1:0] rd_node,
  output logic                      rd_target
);
  import ftt_pkg::*;

  logic [NODE_W:0] mem_r [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_target, wr_node};
    end
  end

  always_ff @(posedge clk) begin
    {rd_target, rd_node} <= mem_r[rd_addr];
  end

endmodule

// File: hw/rtl/node_failover_target_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_failover_target_table_top: node to failover target lookup table
// Set or get the failover target of a node; one result beat per item.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser
//  in_     | in  | [31:0] node_id, [39:32] destination | [0] mode
//  out_    | out | [1:0] status, [2] target            | -
//
// Each item scans the filled entries in order, one entry compared per cycle
// against the registered memory read port; an empty table skips the scan and
// a hit ends it early. A final step then updates the table and loads the
// result register.
// Reset clears the fill count, sequencer state and result valid, not the entries;
// entries past the count are never used. The input is taken when the sequencer
// is idle, even while a result waits. A stalled result holds the sequencer in its final step until taken.
// ----------------------------------------------------------------------------
module node_failover_target_table_top #(
  parameter int unsigned ENTRIES = ftt_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] node_id, [39:32] destination
  input  logic [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] status, [2] target, [7:3] zero
);
  import ftt_pkg::*;

  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned COUNT_W = $clog2(ENTRIES + 1);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(ENTRIES);

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   used_count_r, used_count_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [COUNT_W-1:0]   idx_inc;
  logic                 mode_r, mode_nxt;
  logic [NODE_W-1:0]    node_r, node_nxt;
  logic [DEST_W-1:0]    dest_r, dest_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     hit_slot_r, hit_slot_nxt;
  logic                 hit_tgt_r, hit_tgt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_target_r, out_target_nxt;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [IDX_W-1:0]     rd_addr;
  logic [NODE_W-1:0]    rd_node;
  logic                 rd_target;
  logic                 in_fire;
  logic                 out_free;
  logic                 dest_ok;

  ftt_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_node   (node_r),
    .wr_target (dest_r[0]),
    .rd_addr   (rd_addr),
    .rd_node   (rd_node),
    .rd_target (rd_target)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_target_r, out_status_r};
  assign idx_inc    = COUNT_W'(idx_r) + COUNT_W'(1);
  assign dest_ok    = (dest_r == FO_ACTIVE_ONLY) || (dest_r == FO_ALTERNATE_ONLY);

  always_comb begin
    state_nxt      = state_r;
    used_count_nxt = used_count_r;
    idx_nxt        = idx_r;
    mode_nxt       = mode_r;
    node_nxt       = node_r;
    dest_nxt       = dest_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    hit_tgt_nxt    = hit_tgt_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_target_nxt = out_target_r;
    wr_en          = 1'b0;
    wr_addr        = hit_slot_r;
    rd_addr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt = in_tuser[0];
          node_nxt = in_tdata[NODE_W-1:0];
          dest_nxt = in_tdata[NODE_W +: DEST_W];
          idx_nxt  = '0;
          hit_nxt  = 1'b0;
          // address 0 is already on the read port this cycle
          state_nxt = (used_count_r == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = idx_inc[IDX_W-1:0];
        if (rd_node == node_r) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = idx_r;
          hit_tgt_nxt  = rd_target;
          state_nxt    = S_DONE;
        end else if (idx_inc == used_count_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_inc[IDX_W-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_target_nxt = FO_TGT_DEFAULT;
          state_nxt      = S_IDLE;
          if (mode_r == MODE_GET) begin
            if (hit_r) begin
              out_target_nxt = hit_tgt_r;
            end
          end else if (!dest_ok) begin
            out_status_nxt = ST_BAD_CODE;
          end else if (hit_r) begin
            wr_en = 1'b1;
          end else if (used_count_r == FULL_COUNT) begin
            out_status_nxt = ST_FULL;
          end else begin
            // append at the first free slot
            wr_en          = 1'b1;
            wr_addr        = used_count_r[IDX_W-1:0];
            used_count_nxt = used_count_r + COUNT_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_count_r <= used_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    mode_r       <= mode_nxt;
    node_r       <= node_nxt;
    dest_r       <= dest_nxt;
    hit_r        <= hit_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_tgt_r    <= hit_tgt_nxt;
    out_status_r <= out_status_nxt;
    out_target_r <= out_target_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_count_r <= FULL_COUNT)
    else $error("fill count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (used_count_r != $past(used_count_r))) |->
      (used_count_r == $past(used_count_r) + COUNT_W'(1)))
    else $error("fill count moved by other than one");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (COUNT_W'(idx_r) < used_count_r))
    else $error("scan index past filled entries");

  a_write_on_set: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((state_r == S_DONE) && (mode_r == MODE_SET) && dest_ok && out_free))
    else $error("table written outside a completing set");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for node_failover_target_table_top
// Sends set and get beats with random gaps and random result back-pressure.
// A scoreboard keeps its own copy of the node table, predicts the result of
// each accepted beat and compares the returned beats in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ftt_pkg::*;

  localparam int unsigned ENTRIES    = ENTRIES_DEF;
  localparam int          N_RANDOM   = 700;
  localparam int          POOL_SIZE  = 40;
  localparam int          IDLE_LIMIT = 2000;

  typedef struct packed {
    status_t status;
    logic    target;
  } reply_t;

  class failover_scoreboard;
    logic [NODE_W-1:0] slot_node [ENTRIES];
    logic              slot_target [ENTRIES];
    int                used;
    reply_t            pending_replies[$];
    int                errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("tb_top: mismatch: %s", msg);
    endtask

    function int pending();
      return pending_replies.size();
    endfunction

    // predict one accepted beat and update the shadow table
    function void note_item(logic mode, logic [NODE_W-1:0] node, logic [DEST_W-1:0] dest);
      int     hit;
      reply_t r;
      hit      = -1;
      r.status = ST_OK;
      r.target = FO_TGT_DEFAULT;
      for (int i = 0; i < used; i++) begin
        if (hit < 0 && slot_node[i] == node) hit = i;
      end
      if (mode == MODE_GET) begin
        if (hit >= 0) r.target = slot_target[hit];
      end else if (dest > FO_ALTERNATE_ONLY) begin
        r.status = ST_BAD_CODE;
      end else if (hit >= 0) begin
        slot_target[hit] = dest[0];
      end else if (used >= ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        slot_node[used]   = node;
        slot_target[used] = dest[0];
        used++;
      end
      pending_replies.push_back(r);
    endfunction

    task check_reply(logic [7:0] beat);
      reply_t r;
      if (pending_replies.size() == 0) begin
        report($sformatf("result beat 0x%02h with nothing pending", beat));
      end else begin
        r = pending_replies.pop_front();
        if (beat[1:0] != r.status)
          report($sformatf("status %0d, expected %0d", beat[1:0], r.status));
        if (beat[2] != r.target)
          report($sformatf("target %0d, expected %0d", beat[2], r.target));
        if (beat[7:3] != '0)
          report($sformatf("pad bits 0x%02h not zero", beat[7:3]));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  failover_scoreboard sb;
  logic [NODE_W-1:0]  node_pool [POOL_SIZE];
  int                 send_quiet;
  int                 recv_quiet;

  node_failover_target_table_top #(.ENTRIES(ENTRIES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // draw the wait before a beat, with occasional runs of back-to-back beats
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) quiet = $urandom_range(10, 30);
    return $urandom_range(0, 9);
  endfunction

  task automatic send_item(logic mode, logic [NODE_W-1:0] node, logic [DEST_W-1:0] dest);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= {dest, node};
    in_tuser[0] <= mode;
    do @(posedge clk); while (!in_tready);
    sb.note_item(mode, node, dest);
  endtask

  task automatic send_random();
    logic              mode;
    logic [NODE_W-1:0] node;
    logic [DEST_W-1:0] dest;
    int                pick;
    mode = $urandom_range(0, 1) ? MODE_GET : MODE_SET;
    node = ($urandom_range(0, 99) < 85) ? node_pool[$urandom_range(0, POOL_SIZE-1)]
                                        : $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 4)      dest = FO_ACTIVE_ONLY;
    else if (pick < 8) dest = FO_ALTERNATE_ONLY;
    else               dest = DEST_W'($urandom_range(0, 255));
    send_item(mode, node, dest);
  endtask

  // result side: random back-pressure, check every taken beat
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_reply(out_tdata);
    end
  end

  // watchdog: cycles without any accepted beat on either side
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    sb         = new();
    send_quiet = 0;
    recv_quiet = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    node_pool[0] = 32'h0000_0000;
    node_pool[1] = 32'hFFFF_FFFF;
    node_pool[2] = 32'hA5A5_A5A5;
    for (int i = 3; i < POOL_SIZE; i++) node_pool[i] = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, bad codes, updates, ignored dest on get
    send_item(MODE_GET, 32'h0000_0000, FO_ACTIVE_ONLY);
    send_item(MODE_GET, 32'hFFFF_FFFF, 8'hFF);
    send_item(MODE_SET, 32'h0000_0000, FO_ACTIVE_ONLY);
    send_item(MODE_SET, 32'hFFFF_FFFF, FO_ALTERNATE_ONLY);
    send_item(MODE_GET, 32'h0000_0000, FO_ACTIVE_ONLY);
    send_item(MODE_GET, 32'hFFFF_FFFF, FO_ACTIVE_ONLY);
    send_item(MODE_SET, 32'h1234_5678, 8'h02);
    send_item(MODE_SET, 32'h1234_5678, 8'hFF);
    send_item(MODE_GET, 32'h1234_5678, FO_ALTERNATE_ONLY);
    send_item(MODE_SET, 32'h0000_0000, FO_ALTERNATE_ONLY);
    send_item(MODE_GET, 32'h0000_0000, 8'h80);
    send_item(MODE_SET, 32'hFFFF_FFFF, FO_ACTIVE_ONLY);
    send_item(MODE_GET, 32'hFFFF_FFFF, 8'h7F);
    send_item(MODE_SET, 32'hA5A5_A5A5, FO_ALTERNATE_ONLY);
    send_item(MODE_SET, 32'h5A5A_5A5A, 8'hAA);
    send_item(MODE_GET, 32'hA5A5_A5A5, 8'h55);
    send_item(MODE_GET, 32'h5A5A_5A5A, FO_ACTIVE_ONLY);

    // let the table go fully idle before the random traffic
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    // pool holds more nodes than slots, so the table fills and overflows
    for (int n = 0; n < N_RANDOM; n++) send_random();
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (ENTRIES + 10) @(posedge clk);
    if (sb.pending() != 0) sb.report("results still pending at end");

    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ftt_pkg.sv
hw/rtl/ftt_mem.sv
hw/rtl/node_failover_target_table_top.sv
sim/tb_top.sv
